// File: hw/rtl/dna_triplet_encoder_macros.svh
// Assertion macros used by the dna_triplet_encoder output queue.
`ifndef DNA_TRIPLET_ENCODER_MACROS_SVH
`define DNA_TRIPLET_ENCODER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define DTE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DTE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dte_pkg.sv
// Types, code tables and shared structs for the DNA triplet encoder.
`timescale 1ns / 1ps
`default_nettype none

package dte_pkg;

  typedef logic [1:0] sym_t;

  typedef struct packed {
    sym_t first;
    sym_t middle;
    sym_t last;
  } triplet_t;

  typedef struct packed {
    sym_t code_a;
    sym_t code_b;
    sym_t code_c;
    sym_t code_d;
    logic final_word;
  } word_t;

  // Write requests from the front end into the output queue.
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic [1:0] count;
  } q_status_t;

  localparam sym_t RIGHT_TAB [4][4] = '{
    '{2'd1, 2'd2, 2'd1, 2'd2},
    '{2'd2, 2'd3, 2'd3, 2'd0},
    '{2'd1, 2'd3, 2'd1, 2'd0},
    '{2'd2, 2'd0, 2'd0, 2'd1}
  };

  localparam sym_t LEFT_TAB [4][4] = '{
    '{2'd2, 2'd3, 2'd3, 2'd1},
    '{2'd3, 2'd0, 2'd0, 2'd2},
    '{2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd1, 2'd2, 2'd1, 2'd0}
  };

  // Accept a request only while the queue can take two words.
  localparam logic [1:0] QUEUE_ACCEPT_MAX = 2'd1;

endpackage

`default_nettype wire

// File: hw/rtl/dte_word_enc.sv
// Encodes one triplet and its lookahead symbol into a four-symbol word.
`timescale 1ns / 1ps
`default_nettype none

module dte_word_enc
  import dte_pkg::*;
(
  input  triplet_t trip_i,
  input  sym_t     lookahead_i,
  input  logic     odd_i,
  input  logic     final_i,
  output word_t    word_o
);

  logic first_eq;
  logic last_eq;
  logic replaced;
  sym_t mid;
  sym_t chk;

  always_comb begin
    first_eq = (trip_i.first == trip_i.middle);
    last_eq  = (trip_i.middle == trip_i.last);
    replaced = first_eq || last_eq;

    priority if (first_eq) begin
      mid = LEFT_TAB[trip_i.first][trip_i.last];
    end else if (last_eq) begin
      mid = RIGHT_TAB[trip_i.first][trip_i.last];
    end else begin
      mid = trip_i.middle;
    end

    // Swap the check table on odd words.
    if (replaced != odd_i) begin
      chk = LEFT_TAB[trip_i.last][lookahead_i];
    end else begin
      chk = RIGHT_TAB[trip_i.last][lookahead_i];
    end

    word_o.code_a     = trip_i.first;
    word_o.code_b     = mid;
    word_o.code_c     = trip_i.last;
    word_o.code_d     = chk;
    word_o.final_word = final_i;
  end

endmodule

`default_nettype wire

// File: hw/rtl/dte_out_fifo.sv
// Three-entry output queue taking up to two words per cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "dna_triplet_encoder_macros.svh"

module dte_out_fifo
  import dte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  word_t     word0_i,
  input  word_t     word1_i,
  output q_status_t status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output word_t     word_o
);

  word_t      mem_q [3];
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic [1:0] wr_idx0, wr_idx1;
  logic       pop;

  function automatic logic [1:0] wrap3(input logic [1:0] base, input logic [1:0] inc);
    logic [2:0] sum;
    sum = {1'b0, base} + {1'b0, inc};
    if (sum >= 3'd3) begin
      sum = sum - 3'd3;
    end
    return sum[1:0];
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign word_o      = mem_q[rd_ptr_q];
  assign status_o.count = count_q;

  always_comb begin
    wr_idx0  = wrap3(rd_ptr_q, count_q);
    wr_idx1  = wrap3(rd_ptr_q, count_q + 2'd1);
    rd_ptr_d = pop ? wrap3(rd_ptr_q, 2'd1) : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i.push0} + {1'b0, push_i.push1} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_idx0] <= word0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_idx1] <= word1_i;
    end
  end

  `DTE_ASSERT_ALWAYS(a_ptr_range, rd_ptr_q != 2'd3, "read pointer out of range")
  `DTE_ASSERT_IMPL(a_push_order, push_i.push1, push_i.push0, "second word without first")
  `DTE_ASSERT_IMPL(a_push_room, push_i.push0, count_q <= QUEUE_ACCEPT_MAX, "push into full queue")
  `DTE_ASSERT_NEXT(a_pop_count, pop && !push_i.push0, count_q == $past(count_q) - 2'd1, "pop miscounted")

endmodule

`default_nettype wire

// File: hw/rtl/dna_triplet_encoder.sv
// Top level of the DNA triplet encoder: holding stage, word encoders, output queue.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   in      | input     | in_valid_i/in_ready_o | sym_first/middle/last, end_of_stream
//   out     | output    | out_valid_o/out_ready_i | code_a..code_d, final_word
//   cfg     | input     | cfg_we_i              | cfg_wdata_i (terminal symbol)
//
// One triplet is accepted per cycle while the sink keeps up; a triplet that ends a stream
// while another is held yields two words, and the input then pauses while they drain
// one per cycle through the three-entry output queue.
// A word reaches the output only after the request that completes it writes it into the output queue.
// in_ready_o is high while the queue holds at most one word and does not depend on out_ready_i.
// Reset empties the queue, drops the held triplet, sets the phase to even and the
// terminal symbol to A.
`timescale 1ns / 1ps
`default_nettype none

module dna_triplet_encoder
  import dte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] sym_first_i,
  input  logic [1:0] sym_middle_i,
  input  logic [1:0] sym_last_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] code_a_o,
  output logic [1:0] code_b_o,
  output logic [1:0] code_c_o,
  output logic [1:0] code_d_o,
  output logic       final_word_o
);

  sym_t      term_q;
  triplet_t  held_q, held_d;
  logic      held_valid_q, held_valid_d;
  logic      odd_q, odd_d;
  triplet_t  new_trip;
  logic      accept;
  logic      new_odd;
  word_t     held_word, new_word, out_word;
  push_t     push;
  q_status_t q_status;

  assign new_trip = '{first: sym_first_i, middle: sym_middle_i, last: sym_last_i};
  assign in_ready_o = (q_status.count <= QUEUE_ACCEPT_MAX);
  assign accept = in_valid_i && in_ready_o;
  // The new triplet takes the phase after the held word, if one goes out first.
  assign new_odd = held_valid_q ? !odd_q : odd_q;

  dte_word_enc u_enc_held (
    .trip_i      (held_q),
    .lookahead_i (sym_first_i),
    .odd_i       (odd_q),
    .final_i     (1'b0),
    .word_o      (held_word)
  );

  dte_word_enc u_enc_new (
    .trip_i      (new_trip),
    .lookahead_i (term_q),
    .odd_i       (new_odd),
    .final_i     (1'b1),
    .word_o      (new_word)
  );

  always_comb begin
    push.push0   = accept && (held_valid_q || end_of_stream_i);
    push.push1   = accept && held_valid_q && end_of_stream_i;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    odd_d        = odd_q;
    if (accept) begin
      if (end_of_stream_i) begin
        held_valid_d = 1'b0;
        held_d       = '0;
        odd_d        = 1'b0;
      end else begin
        held_valid_d = 1'b1;
        held_d       = new_trip;
        odd_d        = new_odd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      odd_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        term_q <= cfg_wdata_i;
      end
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      odd_q        <= odd_d;
    end
  end

  dte_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .word0_i     (held_valid_q ? held_word : new_word),
    .word1_i     (new_word),
    .status_o    (q_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (out_word)
  );

  assign code_a_o     = out_word.code_a;
  assign code_b_o     = out_word.code_b;
  assign code_c_o     = out_word.code_c;
  assign code_d_o     = out_word.code_d;
  assign final_word_o = out_word.final_word;

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the DNA triplet encoder with a predictor and word scoreboard.
`timescale 1ns / 1ps

import dte_pkg::*;

class codeword_scoreboard;
  // Replacement and check-symbol tables, indexed [row][column].
  sym_t right_lut [4][4] = '{
    '{2'd1, 2'd2, 2'd1, 2'd2},
    '{2'd2, 2'd3, 2'd3, 2'd0},
    '{2'd1, 2'd3, 2'd1, 2'd0},
    '{2'd2, 2'd0, 2'd0, 2'd1}
  };
  sym_t left_lut [4][4] = '{
    '{2'd2, 2'd3, 2'd3, 2'd1},
    '{2'd3, 2'd0, 2'd0, 2'd2},
    '{2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd1, 2'd2, 2'd1, 2'd0}
  };

  sym_t        terminal_sym;
  triplet_t    held_trip;
  bit          held_valid;
  bit          odd_word;
  word_t       expected_words [$];
  int unsigned mismatches;

  function new();
    terminal_sym = '0;
    held_trip    = '0;
    held_valid   = 1'b0;
    odd_word     = 1'b0;
    mismatches   = 0;
  endfunction

  function void set_terminal(sym_t s);
    terminal_sym = s;
  endfunction

  function int unsigned pending();
    return expected_words.size();
  endfunction

  function word_t encode_word(triplet_t t, sym_t look, bit odd, bit fin);
    word_t w;
    sym_t  mid;
    bit    replaced;
    replaced = 1'b1;
    if (t.first == t.middle) begin
      mid = left_lut[t.first][t.last];
    end else if (t.middle == t.last) begin
      mid = right_lut[t.first][t.last];
    end else begin
      mid = t.middle;
      replaced = 1'b0;
    end
    w.code_a     = t.first;
    w.code_b     = mid;
    w.code_c     = t.last;
    // Table order flips between even and odd words.
    w.code_d     = (replaced != odd) ? left_lut[t.last][look] : right_lut[t.last][look];
    w.final_word = fin;
    return w;
  endfunction

  function void note_request(triplet_t t, logic eos);
    if (held_valid) begin
      expected_words.push_back(encode_word(held_trip, t.first, odd_word, 1'b0));
      odd_word = !odd_word;
    end
    if (eos) begin
      expected_words.push_back(encode_word(t, terminal_sym, odd_word, 1'b1));
      held_valid = 1'b0;
      held_trip  = '0;
      odd_word   = 1'b0;
    end else begin
      held_trip  = t;
      held_valid = 1'b1;
    end
  endfunction

  function void check_word(word_t got);
    word_t exp_w;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: a=%0d b=%0d c=%0d d=%0d fin=%0d",
                 got.code_a, got.code_b, got.code_c, got.code_d, got.final_word);
      return;
    end
    exp_w = expected_words.pop_front();
    if (got.code_a != exp_w.code_a || got.code_b != exp_w.code_b ||
        got.code_c != exp_w.code_c || got.code_d != exp_w.code_d ||
        got.final_word != exp_w.final_word) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word mismatch: expected a=%0d b=%0d c=%0d d=%0d fin=%0d, got a=%0d b=%0d c=%0d d=%0d fin=%0d",
                 exp_w.code_a, exp_w.code_b, exp_w.code_c, exp_w.code_d, exp_w.final_word,
                 got.code_a, got.code_b, got.code_c, got.code_d, got.final_word);
    end
  endfunction
endclass

module tb;
  localparam sym_t NT_A = 2'd0;
  localparam sym_t NT_T = 2'd1;
  localparam sym_t NT_C = 2'd2;
  localparam sym_t NT_G = 2'd3;

  localparam int unsigned QUIET_LIMIT  = 400;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] sym_first_i;
  logic [1:0] sym_middle_i;
  logic [1:0] sym_last_i;
  logic       end_of_stream_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] code_a_o;
  logic [1:0] code_b_o;
  logic [1:0] code_c_o;
  logic [1:0] code_d_o;
  logic       final_word_o;

  codeword_scoreboard codewords;
  bit                 src_gaps_on;
  bit                 sink_stalls_on;
  int unsigned        quiet_cycles;

  dna_triplet_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sym_first_i     (sym_first_i),
    .sym_middle_i    (sym_middle_i),
    .sym_last_i      (sym_last_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_a_o        (code_a_o),
    .code_b_o        (code_b_o),
    .code_c_o        (code_c_o),
    .code_d_o        (code_d_o),
    .final_word_o    (final_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check drained words before noting the new request of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        codewords.check_word({code_a_o, code_b_o, code_c_o, code_d_o, final_word_o});
      if (in_valid_i && in_ready_o)
        codewords.note_request({sym_first_i, sym_middle_i, sym_last_i}, end_of_stream_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: random stall bursts while enabled.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(negedge clk_i);
    end
  end

  // Entered and left at a falling edge; valid stays high on return.
  task automatic push_request(triplet_t t, logic eos);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    sym_first_i     = t.first;
    sym_middle_i    = t.middle;
    sym_last_i      = t.last;
    end_of_stream_i = eos;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_terminal(sym_t s);
    in_valid_i = 1'b0;
    while (codewords.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = s;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    codewords.set_terminal(s);
  endtask

  // Bias toward the replacement rules: equal leading or trailing pairs.
  function automatic triplet_t random_triplet();
    triplet_t t;
    t = triplet_t'($urandom_range(0, 63));
    case ($urandom_range(0, 3))
      0: t.middle = t.first;
      1: t.last = t.middle;
      2: begin
        t.middle = t.first;
        t.last   = t.first;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic run_streams(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 14);
      for (int unsigned k = 0; k < len; k++)
        push_request(random_triplet(), k == len - 1);
      sent += len;
    end
  endtask

  task automatic run_directed();
    // Single-triplet streams: one even final word each.
    push_request(triplet_t'{NT_A, NT_A, NT_A}, 1'b1);
    push_request(triplet_t'{NT_G, NT_G, NT_G}, 1'b1);
    push_request(triplet_t'{NT_T, NT_C, NT_G}, 1'b1);
    // Mixed replacement kinds across even and odd words.
    push_request(triplet_t'{NT_A, NT_A, NT_T}, 1'b0);
    push_request(triplet_t'{NT_T, NT_C, NT_C}, 1'b0);
    push_request(triplet_t'{NT_C, NT_T, NT_G}, 1'b0);
    push_request(triplet_t'{NT_G, NT_G, NT_C}, 1'b0);
    push_request(triplet_t'{NT_T, NT_A, NT_G}, 1'b0);
    push_request(triplet_t'{NT_C, NT_C, NT_C}, 1'b1);
    push_request(triplet_t'{NT_G, NT_C, NT_T}, 1'b0);
    push_request(triplet_t'{NT_A, NT_T, NT_T}, 1'b0);
    push_request(triplet_t'{NT_G, NT_G, NT_A}, 1'b0);
    push_request(triplet_t'{NT_C, NT_A, NT_T}, 1'b0);
    push_request(triplet_t'{NT_T, NT_T, NT_T}, 1'b0);
    push_request(triplet_t'{NT_A, NT_G, NT_G}, 1'b1);
    // No replacement in the first stream, varied lookahead; the last two use leading and trailing pairs.
    push_request(triplet_t'{NT_C, NT_G, NT_A}, 1'b0);
    push_request(triplet_t'{NT_G, NT_T, NT_C}, 1'b0);
    push_request(triplet_t'{NT_A, NT_C, NT_G}, 1'b1);
    push_request(triplet_t'{NT_T, NT_T, NT_G}, 1'b0);
    push_request(triplet_t'{NT_G, NT_A, NT_A}, 1'b1);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    sym_first_i     = '0;
    sym_middle_i    = '0;
    sym_last_i      = '0;
    end_of_stream_i = 1'b0;
    src_gaps_on     = 1'b1;
    sink_stalls_on  = 1'b1;
    codewords       = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    set_terminal(NT_G);
    run_streams(500);
    set_terminal(NT_T);
    run_streams(350);
    set_terminal(sym_t'($urandom_range(0, 3)));
    run_streams(350);
    set_terminal(NT_C);
    run_streams(300);
    set_terminal(NT_A);
    // Back-to-back traffic with an always-ready sink.
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    run_streams(350);

    in_valid_i = 1'b0;
    while (codewords.pending() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (codewords.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dte_pkg.sv
hw/rtl/dte_word_enc.sv
hw/rtl/dte_out_fifo.sv
hw/rtl/dna_triplet_encoder.sv
verif/tb.sv
